// ----- sv/tcw_pkg.sv -----
// ============================================================================
// tcw_pkg: shared types and constants for the text console writer
// Holds the action codes, cell constants and the controller/datapath
// command and status bundles.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Action codes carried in the input tuser field
  typedef enum logic [1:0] {
    ACT_PUT    = 2'd0,
    ACT_SCROLL = 2'd1,
    ACT_READ   = 2'd2
  } tcw_action_e;

  // Configuration register indexes (word index in the APB space)
  localparam logic REG_TEXT_COLOR = 1'b0;

  localparam logic [7:0]  NEWLINE_CODE     = 8'd10;
  localparam logic [7:0]  SPACE_CODE       = 8'd32;
  localparam logic [7:0]  TEXT_COLOR_RESET = 8'h07;
  localparam logic [15:0] CELL_RESET       = {TEXT_COLOR_RESET, SPACE_CODE};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_step;   // write one reset cell and advance the clear pointer
    logic load;       // capture the input transaction
    logic addr_calc;  // register the cell address of the transaction
    logic put;        // store the character and advance the cursor
    logic scr_start;  // rotate the row base and set up the row copy
    logic copy_step;  // one read/write step of the bottom row copy
    logic rd;         // issue the cell read
    logic out_load;   // load the result register
  } tcw_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic       clr_done;
    logic [1:0] action;
    logic       needs_scroll;
    logic       copy_done;
    logic       out_free;
  } tcw_status_t;

endpackage

`default_nettype wire

// ----- sv/tcw_ctrl.sv -----
// ============================================================================
// tcw_ctrl: text console writer controller
// One-hot sequencer: clearing pass after reset, then one transaction at a
// time through address, write/read, row copy and result stages.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tcw_pkg::tcw_status_t status_i,
  output tcw_pkg::tcw_cmd_t    cmd_o
);
  import tcw_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_ADDR   = 8'b0000_0100,
    S_PUT    = 8'b0000_1000,
    S_SCROLL = 8'b0001_0000,
    S_COPY   = 8'b0010_0000,
    S_READ   = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } tcw_state_e;

  tcw_state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd_o.addr_calc = 1'b1;
        case (status_i.action)
          ACT_PUT:    state_d = S_PUT;
          ACT_SCROLL: state_d = S_SCROLL;
          ACT_READ:   state_d = S_READ;
          default:    state_d = S_RESP;
        endcase
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        state_d   = status_i.needs_scroll ? S_SCROLL : S_RESP;
      end
      S_SCROLL: begin
        cmd_o.scr_start = 1'b1;
        state_d         = S_COPY;
      end
      S_COPY: begin
        cmd_o.copy_step = 1'b1;
        if (status_i.copy_done) state_d = S_RESP;
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_RESP;
      end
      S_RESP: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/tcw_dp.sv -----
// ============================================================================
// tcw_dp: text console writer datapath
// Cell memory with a rotating row base, cursor, transaction registers,
// bottom row copy engine, clearing pointer and result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tcw_dp #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tcw_pkg::tcw_cmd_t    cmd_i,
  output tcw_pkg::tcw_status_t status_o,
  input  logic [1:0]           in_action_i,
  input  logic [19:0]          in_data_i,   // char_code[7:0], read_row[12:8], read_col[19:13]
  input  logic [7:0]           text_color_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [31:0]          out_data_o   // cell_value, cursor_row, cursor_col, did_scroll
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int AW    = $clog2(CELLS);
  localparam int KW    = CW + 1;
  localparam int SW    = ((RW > 5) ? RW : 5) + 1;

  // Cell memory and its registered read data
  logic [15:0] mem_q [CELLS];
  logic [15:0] rd_data_q;

  // Transaction registers
  logic [1:0]  action_q;
  logic [7:0]  char_q;
  logic [4:0]  rrow_q;
  logic [6:0]  rcol_q;
  logic [AW-1:0] addr_q;
  logic        in_range_q;

  // Cursor and row base
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] base_q, base_d;
  logic          did_q, did_d;

  // Copy engine and clear pointer
  logic [AW-1:0] src_q, src_d;
  logic [AW-1:0] dst_q, dst_d;
  logic [KW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] clr_q;

  // Result register
  logic        out_valid_q;
  logic [31:0] out_q;

  logic          is_newline;
  logic          at_col_end;
  logic          at_bottom;
  logic [RW:0]   put_sum;
  logic [RW-1:0] put_prow;
  logic [SW-1:0] rd_sum;
  logic [RW-1:0] rd_prow;
  logic          rd_in_range;
  logic [RW-1:0] src_row;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic [15:0]   cell_res;

  assign is_newline = (char_q == NEWLINE_CODE);
  assign at_col_end = (col_q == CW'(COLS - 1));
  assign at_bottom  = (row_q == RW'(ROWS - 1));

  // Map logical rows to physical rows through the rotating base
  assign put_sum  = {1'b0, row_q} + {1'b0, base_q};
  assign put_prow = (put_sum >= (RW + 1)'(ROWS)) ? RW'(put_sum - (RW + 1)'(ROWS))
                                                  : RW'(put_sum);
  assign rd_sum   = SW'(rrow_q) + SW'(base_q);
  assign rd_prow  = (rd_sum >= SW'(ROWS)) ? RW'(rd_sum - SW'(ROWS)) : RW'(rd_sum);
  assign rd_in_range = (32'(rrow_q) < ROWS) && (32'(rcol_q) < COLS);

  // Old bottom row sits just above the base
  assign src_row = (base_q == '0) ? RW'(ROWS - 1) : base_q - 1'b1;

  // Status to the controller
  always_comb begin
    status_o.clr_done     = (clr_q == AW'(CELLS - 1));
    status_o.action       = action_q;
    status_o.needs_scroll = (is_newline || at_col_end) && at_bottom;
    status_o.copy_done    = (cnt_q == KW'(COLS));
    status_o.out_free     = !out_valid_q || out_ready_i;
  end

  // Memory port selection
  always_comb begin
    mem_we = cmd_i.clr_step || (cmd_i.put && !is_newline) ||
             (cmd_i.copy_step && (cnt_q != '0));
    if (cmd_i.clr_step) begin
      mem_wa = clr_q;
      mem_wd = CELL_RESET;
    end else if (cmd_i.put) begin
      mem_wa = addr_q;
      mem_wd = {text_color_i, char_q};
    end else begin
      mem_wa = dst_q;
      mem_wd = rd_data_q;
    end
    mem_re = cmd_i.rd || (cmd_i.copy_step && (cnt_q != KW'(COLS)));
    mem_ra = cmd_i.rd ? addr_q : src_q;
  end

  // Cursor, base and copy engine next state
  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    base_d = base_q;
    did_d  = did_q;
    src_d  = src_q;
    dst_d  = dst_q;
    cnt_d  = cnt_q;
    if (cmd_i.load) begin
      did_d = 1'b0;
    end
    if (cmd_i.put) begin
      if (is_newline || at_col_end) begin
        col_d = '0;
        if (!at_bottom) row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
    if (cmd_i.scr_start) begin
      did_d  = 1'b1;
      base_d = (base_q == RW'(ROWS - 1)) ? '0 : base_q + 1'b1;
      src_d  = AW'(32'(src_row) * COLS);
      dst_d  = AW'(32'(base_q) * COLS);
      cnt_d  = '0;
      if (action_q == ACT_SCROLL && row_q != '0) row_d = row_q - 1'b1;
    end
    if (cmd_i.copy_step) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q != KW'(COLS)) src_d = src_q + 1'b1;
      if (cnt_q != '0) dst_d = dst_q + 1'b1;
    end
  end

  // Result value
  assign cell_res = (action_q == ACT_READ && in_range_q) ? rd_data_q : '0;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      base_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      base_q <= base_d;
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    did_q <= did_d;
    src_q <= src_d;
    dst_q <= dst_d;
    cnt_q <= cnt_d;
    if (cmd_i.load) begin
      action_q <= in_action_i;
      char_q   <= in_data_i[7:0];
      rrow_q   <= in_data_i[12:8];
      rcol_q   <= in_data_i[19:13];
    end
    if (cmd_i.addr_calc) begin
      in_range_q <= rd_in_range;
      if (action_q == ACT_READ) begin
        addr_q <= AW'(32'(rd_prow) * COLS + 32'(rcol_q));
      end else begin
        addr_q <= AW'(32'(put_prow) * COLS + 32'(col_q));
      end
    end
    if (cmd_i.out_load) begin
      out_q <= {3'b000, did_q, 7'(col_q), 5'(row_q), cell_res};
    end
  end

  // Cell memory write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rd_data_q <= mem_q[mem_ra];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- sv/text_console_writer.sv -----
// Put and read run the address, put/read and result states; an unused action skips to result.
// A scroll, and a put that wraps or newlines past the bottom row, also run the scroll and copy states:
// rows rotate through a base pointer and only the bottom row is copied, one cell a cycle.
// Throughput: one transaction at a time; the next is taken once the result register is loaded.
// Reset: asynchronous active-low; a clearing pass then writes ROWS*COLS cells
// with a grey space while s_tready stays low.
// ============================================================================
// text_console_writer: text-mode console engine
// Character cell store with cursor, wrap, newline and scroll handling,
// a stream input and output and an APB color register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13], zero pad
  input  logic [1:0]  s_tuser,   // action[1:0]
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cell_value[15:0], cursor_row[20:16], cursor_col[27:21],
                                 // did_scroll[28], zero pad
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcw_pkg::*;

  tcw_cmd_t    cmd;
  tcw_status_t status;
  logic [7:0]  text_color_q;
  logic        cfg_wr;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_TEXT_COLOR) ? {24'd0, text_color_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= TEXT_COLOR_RESET;
    end else if (cfg_wr && paddr[2] == REG_TEXT_COLOR) begin
      text_color_q <= pwdata[7:0];
    end
  end

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcw_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_action_i  (s_tuser),
    .in_data_i    (s_tdata[19:0]),
    .text_color_i (text_color_q),
    .out_ready_i  (m_tready),
    .out_valid_o  (m_tvalid),
    .out_data_o   (m_tdata)
  );

`ifndef SYNTHESIS
  // One transaction in flight: no accept in the cycle after an accept
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a transaction is in progress");

  // The memory write port is claimed by at most one source
  a_write_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr_step, cmd.put, cmd.copy_step}))
    else $error("memory write port claimed twice");

  // The result register is loaded only when free
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten before it was taken");
`endif

endmodule

`default_nettype wire
